// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tbst_pkg.sv
`timescale 1ns / 1ps
package tbst_pkg;
  localparam int TableEntries = 16;
  localparam int SlotW = $clog2(TableEntries);
  localparam logic [31:0] BlockSizeReset = 32'd65536;
  localparam logic [1:0] RegBlockSize = 2'd0;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_PULL   = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_SIZE   = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One table entry as it is stored in the entry memory.
  typedef struct packed {
    logic [63:0] size;
    logic [63:0] block_count;
    logic [63:0] next_block;
    logic        done;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Result of the key lookup handed to the sequencer.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             free;
    logic [SlotW-1:0] free_slot;
  } lookup_t;
endpackage

// File: rtl/tbst_ram.sv
`timescale 1ns / 1ps
module tbst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/tbst_keys.sv
`timescale 1ns / 1ps
module tbst_keys import tbst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [63:0]      key,
  input  logic             set_valid,
  input  logic             clr_valid,
  input  logic [SlotW-1:0] slot,
  output lookup_t          lookup
);
  logic [TableEntries-1:0] valid_r;
  logic [63:0]             key_r [TableEntries];
  lookup_t                 lk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (set_valid) begin
      valid_r[slot] <= 1'b1;
    end else if (clr_valid) begin
      valid_r[slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (set_valid) begin
      key_r[slot] <= key;
    end
  end

  always_comb begin
    lk = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == key) begin
        lk.hit = 1'b1;
        lk.hit_slot = SlotW'(i);
      end
      if (!valid_r[i]) begin
        lk.free = 1'b1;
        lk.free_slot = SlotW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    lookup <= lk;
  end
endmodule

// File: rtl/tbst_div.sv
`timescale 1ns / 1ps
module tbst_div import tbst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] count
);
  logic [63:0] quo_r;
  logic [32:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_r[31:0], quo_r[63]};
  assign trial = shifted - {1'b0, dvs_r};
  assign busy = cnt_r != 7'd0;
  assign count = (dvs_r == 32'd0) ? 64'd0 : quo_r + {63'd0, rem_r != 33'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 7'd64;
    end else if (busy) begin
      cnt_r <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem_r <= trial;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/transfer_block_segmentation_table.sv
`timescale 1ns / 1ps
// Channel  | Ports                     | Content
// input    | in_tvalid/tready/tdata    | command, transfer_id, total_size
// result   | out_tvalid/tready/tdata   | status, block_offset, read_length, finished, size_out
// config   | cfg_psel..cfg_prdata      | block_size at address 0
// Lookup, entry read and decision are the states S_LOOK, S_READ and S_DEC; query,
// size, remove and error results are registered in S_DEC and leave from the output register.
// Pull adds S_MUL for the offset multiply and S_WRITE for the entry update.
// Insert runs a 64-step restoring divider in S_DIV. A new word is taken only in S_IDLE.
// Reset is synchronous; block_size returns to 65536, valid bits clear, entry
// memory contents stay undefined. A waiting result does not stop the next word
// from being taken; that word waits in S_DEC, S_DIV or S_WRITE until the result leaves.
module transfer_block_segmentation_table import tbst_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // command[2:0], transfer_id[66:3], total_size[130:67]
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], block_offset[65:2], read_length[97:66], finished[98], size_out[162:99]
  output logic [167:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_READ, S_DEC, S_DIV, S_MUL, S_WRITE
  } state_t;

  state_t      state_r;
  logic [31:0] block_size_r;
  logic [2:0]  cmd_r;
  logic [63:0] key_r;
  logic [63:0] size_r;
  logic [SlotW-1:0] slot_r;
  entry_t      ent_r;
  logic [63:0] plo_r, phi_r;
  logic        obuf_v_r;
  logic [167:0] obuf_r;

  lookup_t lookup;
  entry_t  rd_entry;
  logic    ram_we;
  entry_t  ram_wdata;
  logic    set_valid, clr_valid;
  logic    div_start, div_busy;
  logic [63:0] div_count;
  logic [63:0] offset;
  logic [63:0] last_len;
  logic [SlotW-1:0] key_slot;
  logic    res_ok;
  logic    res_fire;
  logic    is_last;
  logic [31:0] pull_len;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = block_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BlockSizeReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegBlockSize) begin
      block_size_r <= cfg_pwdata;
    end
  end

  assign key_slot = (state_r == S_DEC) ? lookup.hit_slot : slot_r;

  tbst_keys u_keys (
    .clk, .rst_n, .key(key_r), .set_valid, .clr_valid, .slot(key_slot), .lookup
  );

  tbst_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk, .we(ram_we), .waddr(slot_r), .wdata(ram_wdata),
    .raddr(lookup.hit_slot), .rdata(rd_entry)
  );

  tbst_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(size_r), .divisor(block_size_r),
    .busy(div_busy), .count(div_count)
  );

  assign in_tready = (state_r == S_IDLE);
  assign res_ok = !obuf_v_r || out_tready;
  assign out_tvalid = obuf_v_r;
  assign out_tdata = obuf_r;
  assign offset = plo_r + {phi_r[31:0], 32'd0};
  assign last_len = ent_r.size - offset;
  assign is_last = (ent_r.next_block == ent_r.block_count - 64'd1);
  assign pull_len = is_last ? last_len[31:0] : block_size_r;

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = ent_r;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    div_start = 1'b0;
    res_fire = 1'b0;
    if (state_r == S_DEC && res_ok) begin
      if (cmd_r == CMD_INSERT && !lookup.hit && lookup.free) begin
        div_start = 1'b1;
      end else if (!(cmd_r == CMD_PULL && lookup.hit)) begin
        res_fire = 1'b1;
      end
      if (cmd_r == CMD_REMOVE && lookup.hit) begin
        clr_valid = 1'b1;
      end
    end
    if (state_r == S_DIV && !div_busy && res_ok) begin
      ram_we = 1'b1;
      ram_wdata = '{size: size_r, block_count: div_count, next_block: 64'd0, done: 1'b0};
      set_valid = 1'b1;
      res_fire = 1'b1;
    end
    if (state_r == S_WRITE && res_ok) begin
      ram_we = 1'b1;
      ram_wdata.next_block = ent_r.next_block + 64'd1;
      ram_wdata.done = ent_r.done || is_last;
      res_fire = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      obuf_v_r <= 1'b0;
    end else begin
      if (res_fire) begin
        obuf_v_r <= 1'b1;
      end else if (out_tready) begin
        obuf_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r   <= in_tdata[2:0];
            key_r   <= in_tdata[66:3];
            size_r  <= in_tdata[130:67];
            state_r <= S_LOOK;
          end
        end
        S_LOOK: state_r <= S_READ;
        S_READ: state_r <= S_DEC;
        S_DEC: begin
          if (res_ok) begin
            ent_r <= rd_entry;
            slot_r <= (cmd_r == CMD_INSERT) ? lookup.free_slot : lookup.hit_slot;
            if (cmd_r == CMD_INSERT) begin
              if (lookup.hit) begin
                obuf_r <= {166'd0, ST_DUPLICATE};
                state_r <= S_IDLE;
              end else if (!lookup.free) begin
                obuf_r <= {166'd0, ST_FULL};
                state_r <= S_IDLE;
              end else begin
                state_r <= S_DIV;
              end
            end else if (cmd_r > CMD_REMOVE) begin
              obuf_r <= '0;
              state_r <= S_IDLE;
            end else if (!lookup.hit) begin
              obuf_r <= {166'd0, ST_NOT_FOUND};
              state_r <= S_IDLE;
            end else if (cmd_r == CMD_PULL) begin
              state_r <= S_MUL;
            end else begin
              if (cmd_r == CMD_QUERY) begin
                obuf_r <= {69'd0, rd_entry.done, 98'd0};
              end else if (cmd_r == CMD_SIZE) begin
                obuf_r <= {5'd0, rd_entry.size, 99'd0};
              end else begin
                obuf_r <= '0;
              end
              state_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (!div_busy && res_ok) begin
            obuf_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_MUL: begin
          plo_r <= ent_r.next_block[31:0] * block_size_r;
          phi_r <= ent_r.next_block[63:32] * block_size_r;
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (res_ok) begin
            obuf_r <= {70'd0, pull_len, offset, ST_OK};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/tbst_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbst_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata,
  input logic         cfg_pready
);
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result dropped while stalled")
  `ASSERT_CLK(a_no_accept_busy, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "word taken while busy")
  `ASSERT_CLK(a_out_known, clk, rst_n, out_tvalid |-> !$isunknown(out_tdata), "result word unknown")
  `ASSERT_CLK_NORST(a_pready, clk, cfg_pready, "pready low")
endmodule

bind transfer_block_segmentation_table tbst_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_pready
);
